FILE: design/bchc_pkg.sv
`timescale 1ns / 1ps

package bchc_pkg;

   localparam int NUM_BUTTONS = 2;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_SINGLE  = 3'd1;
   localparam logic [2:0] EV_RELEASE = 3'd2;
   localparam logic [2:0] EV_DOUBLE  = 3'd3;
   localparam logic [2:0] EV_HOLD    = 3'd4;

   localparam logic [2:0] CSR_TICK_PERIOD = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT0    = 3'd1;

   localparam logic [7:0]  TICK_PERIOD_RESET = 8'd10;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd1000;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_PRESSED  = 3'd1,
      ST_RELEASED = 3'd2,
      ST_SECOND   = 3'd3,
      ST_HOLD     = 3'd4
   } state_type;

   typedef struct packed {
      logic       opcode;
      logic [3:0] pin_levels;
      logic [1:0] button_index;
   } req_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic       buzzer_stop;
   } rsp_type;

   typedef struct packed {
      logic tick;
      logic clear;
      logic pressed;
   } lane_ctrl_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic       buzzer_stop;
   } lane_status_type;

endpackage

FILE: design/bchc_lane.sv
`timescale 1ns / 1ps

module bchc_lane
   import bchc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  lane_ctrl_type   ctrl,
   input  logic [7:0]      period,
   input  logic [15:0]     limit,
   output lane_status_type status
);

   state_type   state_ff, state_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [2:0]  latched_ff, latched_in;
   logic [16:0] sum;
   logic [15:0] advanced;
   logic        expired;
   logic        stop;

   assign sum      = {1'b0, elapsed_ff} + {9'd0, period};
   assign advanced = sum[16] ? 16'hFFFF : sum[15:0];
   assign expired  = advanced >= limit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.pressed) state_in = ST_PRESSED;
         end
         ST_PRESSED: begin
            if (expired) state_in = ST_HOLD;
            else if (!ctrl.pressed) state_in = ST_RELEASED;
         end
         ST_RELEASED: begin
            if (expired) state_in = ST_IDLE;
            else if (ctrl.pressed) state_in = ST_SECOND;
         end
         ST_SECOND: begin
            if (expired) state_in = ST_HOLD;
            else if (!ctrl.pressed) state_in = ST_IDLE;
         end
         ST_HOLD: begin
            if (!ctrl.pressed) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // counter, latched event, buzzer stop
   always_comb begin
      elapsed_in = elapsed_ff;
      latched_in = latched_ff;
      stop       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.pressed) begin
               elapsed_in = '0;
               latched_in = EV_SINGLE;
            end
         end
         ST_PRESSED: begin
            elapsed_in = advanced;
            if (expired) latched_in = EV_HOLD;
            else if (!ctrl.pressed) latched_in = EV_RELEASE;
         end
         ST_RELEASED: begin
            elapsed_in = advanced;
            if (expired) latched_in = EV_NONE;
            else if (ctrl.pressed) latched_in = EV_DOUBLE;
         end
         ST_SECOND: begin
            elapsed_in = advanced;
            if (expired) latched_in = EV_HOLD;
            else if (!ctrl.pressed) latched_in = EV_DOUBLE;
         end
         ST_HOLD: begin
            if (!ctrl.pressed) begin
               latched_in = EV_NONE;
               stop       = 1'b1;
            end
         end
         default: latched_in = EV_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         elapsed_ff <= '0;
         latched_ff <= EV_NONE;
      end else if (ctrl.tick) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
         latched_ff <= latched_in;
      end else if (ctrl.clear) begin
         latched_ff <= EV_NONE;
      end
   end

   assign status.event_code  = latched_ff;
   assign status.buzzer_stop = ctrl.tick & stop;

   a_press_from_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.tick && state_ff == ST_IDLE && ctrl.pressed
      |=> elapsed_ff == 16'd0 && latched_ff == EV_SINGLE && state_ff == ST_PRESSED)
      else $error("press from idle did not start a new press");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear && !ctrl.tick |=> latched_ff == EV_NONE)
      else $error("read did not clear latched event");

   a_stop_leaves_hold: assert property (@(posedge clock) disable iff (reset)
      status.buzzer_stop |=> state_ff == ST_IDLE && $past(state_ff) == ST_HOLD)
      else $error("buzzer stop without leaving hold");

endmodule

FILE: design/bchc_merge.sv
`timescale 1ns / 1ps

module bchc_merge
   import bchc_pkg::*;
(
   input  req_type         req,
   input  lane_status_type lanes [NUM_BUTTONS],
   output rsp_type         rsp
);

   always_comb begin
      rsp = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if (req.opcode == OP_TICK) begin
            rsp.buzzer_stop = rsp.buzzer_stop | lanes[b].buzzer_stop;
         end else if ({1'b0, req.button_index} == 3'(b)) begin
            rsp.event_code = lanes[b].event_code;
         end
      end
   end

endmodule

FILE: design/button_click_hold_classifier.sv
`timescale 1ns / 1ps

// Click and hold classifier for NUM_BUTTONS active-low buttons, one state
// machine per button running side by side. A tick transfer steps every
// button; a read transfer returns one button's latched event and clears it.
// Requests are accepted one per clock unless stalled, and each response
// appears in the output register on the next cycle. The request side stalls
// only while that register holds a response the consumer is stalling.
// Configuration writes take effect on the next cycle and must be issued
// while no response is outstanding.

module button_click_hold_classifier
   import bchc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [7:0]      period_ff;
   logic [15:0]     timeout_ff [NUM_BUTTONS];
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff;
   rsp_type         merged;
   logic            accept;
   lane_status_type lane_status [NUM_BUTTONS];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= TICK_PERIOD_RESET;
         for (int b = 0; b < NUM_BUTTONS; b++) timeout_ff[b] <= TIMEOUT_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_TICK_PERIOD) period_ff <= csr_wdata[7:0];
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (csr_index == 3'(CSR_TIMEOUT0 + b)) timeout_ff[b] <= csr_wdata;
         end
      end
   end

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      lane_ctrl_type ctrl;

      assign ctrl.tick    = accept & (req_data.opcode == OP_TICK);
      assign ctrl.clear   = accept & (req_data.opcode == OP_READ)
                            & ({1'b0, req_data.button_index} == 3'(g));
      assign ctrl.pressed = ~req_data.pin_levels[g];

      bchc_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .period (period_ff),
         .limit  (timeout_ff[g]),
         .status (lane_status[g])
      );
   end

   bchc_merge u_merge (
      .req   (req_data),
      .lanes (lane_status),
      .rsp   (merged)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= merged;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_tick_no_event: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.opcode == OP_TICK |=> rsp_data_ff.event_code == EV_NONE)
      else $error("tick response carries an event code");

   a_stall_holds_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled response changed");

endmodule
